// ===== hw/rtl/apgdet_pkg.sv =====
`timescale 1ns / 1ps

package apgdet_pkg;

    // Field widths.
    localparam int ALT_W     = 25;
    localparam int VEL_W     = 18;
    localparam int ACC_W     = 18;
    localparam int TIME_W    = 32;
    localparam int CONF_W    = 10;
    localparam int RUN_W     = 5;

    // Configuration register widths and indexes.
    localparam int MARGIN_W  = 17;
    localparam int CONFIRM_W = 5;
    localparam int ARMING_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_MARGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARMING_ALTITUDE = 2'd2;

    localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = 17'd200;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 5'd5;
    localparam logic [ARMING_W-1:0]  ARMING_RESET  = 24'd5000;

    // Detection thresholds.
    localparam logic [RUN_W-1:0] RUN_MAX = 5'd31;
    localparam int VEL_NOW_LIMIT = -50;
    localparam int VEL_AVG_LIMIT = 20;
    localparam logic [ACC_W-1:0] FALL_LOW  = 18'd9000;
    localparam logic [ACC_W-1:0] FALL_HIGH = 18'd10500;

    localparam logic [CONF_W-1:0] WEIGHT_VEL   = 10'd500;
    localparam logic [CONF_W-1:0] WEIGHT_CURVE = 10'd300;
    localparam logic [CONF_W-1:0] WEIGHT_FALL  = 10'd200;
    localparam logic [CONF_W-1:0] CONF_ADVANCED = 10'd600;
    localparam logic [CONF_W-1:0] CONF_STRONG   = 10'd800;
    localparam logic [CONF_W-1:0] CONF_MAX      = 10'd1000;

    // Smoothing: floor((300*new + 700*old)/1000) = floor((3*new + 7*old)/10).
    localparam int SMOOTH_W     = 14;
    localparam int RECIP_W      = 16;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
    localparam int RECIP_SHIFT  = 19;

endpackage

// ===== hw/rtl/apogee_detector.sv =====
`timescale 1ns / 1ps

// Apogee detector for a stream of filtered flight samples.
// Input channel (i_in_valid / o_in_ready): one request per sample, carrying
// altitude, vertical velocity, acceleration magnitude and a timestamp.
// Output channel (o_out_valid / i_out_ready): one result request per sample,
// in order, carrying the detection flags, latched apogee, peak altitude and
// smoothed confidence as they stand after that sample.
// A sample is captured in an input register and is evaluated when the result
// register loads, which can wait while the receiver stalls; one sample is taken
// every cycle while results keep being taken. The state update is a single
// pass through the running velocity sum, the peak compare and the constant
// multiplies for the smoothing. When the receiver stalls, the result stays on
// the output and one more sample can wait in the input register; the input
// side stalls after that. Configuration writes take effect on the next edge;
// the user must make them while idle, which the block itself does not enforce.
// Reset (synchronous, active low) clears the peak, counters, confidence and
// detection latch and loads the register defaults; no clearing pass is needed.
module apogee_detector #(
    parameter int ALT_HISTORY_DEPTH = 20,
    parameter int VEL_HISTORY_DEPTH = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [apgdet_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [apgdet_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [apgdet_pkg::ALT_W-1:0]   i_altitude_cm,
    input  logic signed [apgdet_pkg::VEL_W-1:0]   i_velocity_cms,
    input  logic [apgdet_pkg::ACC_W-1:0]          i_accel_magnitude_mms2,
    input  logic [apgdet_pkg::TIME_W-1:0]         i_timestamp_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_apogee_detected,
    output logic                                  o_apogee_now,
    output logic signed [apgdet_pkg::ALT_W-1:0]   o_apogee_altitude_cm,
    output logic signed [apgdet_pkg::ALT_W-1:0]   o_peak_altitude_cm,
    output logic [apgdet_pkg::CONF_W-1:0]         o_confidence_milli,
    output logic [apgdet_pkg::TIME_W-1:0]         o_apogee_time_ms
);
    import apgdet_pkg::*;

    localparam int AFW  = $clog2(ALT_HISTORY_DEPTH + 1);
    localparam int VFW  = $clog2(VEL_HISTORY_DEPTH + 1);
    localparam int RSW  = (VEL_HISTORY_DEPTH > 1) ? $clog2(VEL_HISTORY_DEPTH) : 1;
    localparam int SUMW = VEL_W + VFW;
    localparam int ACW  = (AFW > CONFIRM_W) ? AFW : CONFIRM_W;
    localparam int VCW  = (VFW > CONFIRM_W) ? VFW : CONFIRM_W;
    localparam int DW   = ALT_W + 1;
    localparam int D2W  = ALT_W + 3;
    localparam int PRODW = SMOOTH_W + RECIP_W;

    localparam logic [AFW-1:0] ALT_FILL_MAX = AFW'(ALT_HISTORY_DEPTH);
    localparam logic [VFW-1:0] VEL_FILL_MAX = VFW'(VEL_HISTORY_DEPTH);
    localparam logic [RSW-1:0] SLOT_LAST    = RSW'(VEL_HISTORY_DEPTH - 1);

    // Configuration.
    logic [MARGIN_W-1:0]  r_margin;
    logic [CONFIRM_W-1:0] r_confirm;
    logic [ARMING_W-1:0]  r_arming;

    // Input stage.
    logic                     r_s1_valid;
    logic signed [ALT_W-1:0]  r_in_alt;
    logic signed [VEL_W-1:0]  r_in_vel;
    logic [ACC_W-1:0]         r_in_acc;
    logic [TIME_W-1:0]        r_in_time;

    // Detector state; apart from r_out_valid it changes only when a result loads, so it is the result.
    logic                     r_out_valid;
    logic                     r_now;
    logic                     r_detected;
    logic signed [ALT_W-1:0]  r_latched_alt;
    logic [TIME_W-1:0]        r_latched_time;
    logic signed [ALT_W-1:0]  r_peak;
    logic [CONF_W-1:0]        r_conf;
    logic [RUN_W-1:0]         r_run;
    logic signed [ALT_W-1:0]  r_alt_prev1;
    logic signed [ALT_W-1:0]  r_alt_prev2;
    logic [AFW-1:0]           r_alt_fill;
    logic signed [VEL_W-1:0]  r_vel_ring [VEL_HISTORY_DEPTH];
    logic [VFW-1:0]           r_vel_fill;
    logic signed [SUMW-1:0]   r_vel_total;
    logic [RSW-1:0]           r_ring_slot;

    logic                     n_now;
    logic                     n_detected;
    logic signed [ALT_W-1:0]  n_latched_alt;
    logic [TIME_W-1:0]        n_latched_time;
    logic signed [ALT_W-1:0]  n_peak;
    logic [CONF_W-1:0]        n_conf;
    logic [RUN_W-1:0]         n_run;
    logic [AFW-1:0]           n_alt_fill;
    logic [VFW-1:0]           n_vel_fill;
    logic signed [SUMW-1:0]   n_vel_total;
    logic [RSW-1:0]           n_ring_slot;

    logic                     s1_go;
    logic [CONFIRM_W-1:0]     need;
    logic                     armed;
    logic                     alt_enough;
    logic                     vel_enough;
    logic signed [DW-1:0]     drop;
    logic signed [SUMW-1:0]   avg_check;
    logic signed [D2W-1:0]    d2;
    logic                     vel_ok;
    logic                     curve_ok;
    logic                     fall_ok;
    logic                     basic;
    logic                     advanced;
    logic [CONF_W-1:0]        combined;
    logic [SMOOTH_W-1:0]      smooth_sum;
    logic [PRODW-1:0]         smooth_prod;
    logic [CONF_W-1:0]        smooth_conf;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_comb begin
        need = (r_confirm == '0) ? CONFIRM_W'(1) : r_confirm;

        n_alt_fill  = (r_alt_fill < ALT_FILL_MAX) ? r_alt_fill + AFW'(1) : r_alt_fill;
        n_vel_fill  = (r_vel_fill < VEL_FILL_MAX) ? r_vel_fill + VFW'(1) : r_vel_fill;
        n_ring_slot = (r_ring_slot == SLOT_LAST) ? '0 : r_ring_slot + RSW'(1);

        n_vel_total = r_vel_total + SUMW'(r_in_vel);
        if (r_vel_fill >= VEL_FILL_MAX) begin
            n_vel_total = n_vel_total - SUMW'(r_vel_ring[r_ring_slot]);
        end

        n_peak = (r_in_alt > r_peak) ? r_in_alt : r_peak;

        armed = !r_detected &&
                ($signed({n_peak[ALT_W-1], n_peak}) >= $signed({2'b00, r_arming}));
        alt_enough = ACW'(n_alt_fill) >= ACW'(need);
        vel_enough = VCW'(n_vel_fill) >= VCW'(need);

        drop = $signed({n_peak[ALT_W-1], n_peak}) - $signed({r_in_alt[ALT_W-1], r_in_alt});

        n_run = r_run;
        if (armed && alt_enough) begin
            if (drop > $signed(DW'(r_margin))) begin
                n_run = (r_run < RUN_MAX) ? r_run + RUN_W'(1) : r_run;
            end else begin
                n_run = '0;
            end
        end
        basic = alt_enough && (n_run >= RUN_W'(need));

        avg_check = n_vel_total + $signed(SUMW'(n_vel_fill) * SUMW'(VEL_AVG_LIMIT));
        vel_ok    = (r_in_vel < VEL_W'(VEL_NOW_LIMIT)) && avg_check[SUMW-1];
        d2        = D2W'(r_in_alt) - (D2W'(r_alt_prev1) <<< 1) + D2W'(r_alt_prev2);
        curve_ok  = (n_alt_fill >= AFW'(3)) && d2[D2W-1];
        fall_ok   = (r_in_acc < FALL_HIGH) && (r_in_acc > FALL_LOW);

        combined = (vel_ok ? WEIGHT_VEL : '0) + (curve_ok ? WEIGHT_CURVE : '0)
                 + (fall_ok ? WEIGHT_FALL : '0);
        smooth_sum  = SMOOTH_W'(combined) * SMOOTH_W'(3) + SMOOTH_W'(r_conf) * SMOOTH_W'(7);
        smooth_prod = PRODW'(smooth_sum) * PRODW'(RECIP_TEN);
        smooth_conf = smooth_prod[RECIP_SHIFT +: CONF_W];

        n_conf   = (armed && vel_enough) ? smooth_conf : r_conf;
        advanced = armed && vel_enough && (n_conf > CONF_ADVANCED);

        n_now          = armed && advanced && (basic || (n_conf > CONF_STRONG));
        n_detected     = r_detected || n_now;
        n_latched_alt  = n_now ? n_peak : r_latched_alt;
        n_latched_time = n_now ? r_in_time : r_latched_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin  <= MARGIN_RESET;
            r_confirm <= CONFIRM_RESET;
            r_arming  <= ARMING_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DESCENT_MARGIN:  r_margin  <= i_cfg_data[MARGIN_W-1:0];
                CFG_CONFIRM_SAMPLES: r_confirm <= i_cfg_data[CONFIRM_W-1:0];
                CFG_ARMING_ALTITUDE: r_arming  <= i_cfg_data[ARMING_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_alt  <= i_altitude_cm;
            r_in_vel  <= i_velocity_cms;
            r_in_acc  <= i_accel_magnitude_mms2;
            r_in_time <= i_timestamp_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_now          <= 1'b0;
            r_detected     <= 1'b0;
            r_latched_alt  <= '0;
            r_latched_time <= '0;
            r_peak         <= '0;
            r_conf         <= '0;
            r_run          <= '0;
            r_alt_fill     <= '0;
            r_vel_fill     <= '0;
            r_vel_total    <= '0;
            r_ring_slot    <= '0;
        end else if (s1_go) begin
            r_out_valid    <= 1'b1;
            r_now          <= n_now;
            r_detected     <= n_detected;
            r_latched_alt  <= n_latched_alt;
            r_latched_time <= n_latched_time;
            r_peak         <= n_peak;
            r_conf         <= n_conf;
            r_run          <= n_run;
            r_alt_fill     <= n_alt_fill;
            r_vel_fill     <= n_vel_fill;
            r_vel_total    <= n_vel_total;
            r_ring_slot    <= n_ring_slot;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_alt_prev1              <= r_in_alt;
            r_alt_prev2              <= r_alt_prev1;
            r_vel_ring[r_ring_slot]  <= r_in_vel;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_apogee_detected    = r_detected;
    assign o_apogee_now         = r_now;
    assign o_apogee_altitude_cm = r_latched_alt;
    assign o_peak_altitude_cm   = r_peak;
    assign o_confidence_milli   = r_conf;
    assign o_apogee_time_ms     = r_latched_time;

    a_now_implies_detected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_now |-> r_detected)
        else $error("apogee_now without apogee_detected");

    a_detected_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_detected |=> r_detected)
        else $error("detection latch cleared");

    a_conf_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conf <= CONF_MAX)
        else $error("confidence above full scale");

    a_frozen_after_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_detected |=> ($stable(r_conf) && $stable(r_run) && $stable(r_latched_time)))
        else $error("detector state moved after apogee");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_slot <= SLOT_LAST)
        else $error("velocity ring slot out of range");
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import apgdet_pkg::*;

    localparam int ALT_DEPTH = 20;
    localparam int VEL_DEPTH = 10;
    localparam longint ALT_MIN = -1000000;
    localparam longint ALT_MAX = 10000000;
    localparam longint VEL_LIM = 100000;
    localparam longint ACC_MAX = 200000;
    localparam int STALL_LIMIT = 2000;
    localparam int EXPECT_DEPTH = 1024;

    typedef struct packed {
        logic signed [ALT_W-1:0] alt;
        logic signed [VEL_W-1:0] vel;
        logic [ACC_W-1:0]        acc;
        logic [TIME_W-1:0]       ts;
    } sample_t;

    typedef struct packed {
        logic                    detected;
        logic                    fired;
        logic signed [ALT_W-1:0] apogee_alt;
        logic signed [ALT_W-1:0] peak;
        logic [CONF_W-1:0]       conf;
        logic [TIME_W-1:0]       apogee_ms;
    } verdict_t;

    typedef struct packed {
        logic signed [ALT_W-1:0]       peak;
        logic [RUN_W-1:0]              run;
        logic [CONF_W-1:0]             conf;
        logic                          detected;
        logic                          fired;
        logic signed [ALT_W-1:0]       apogee_alt;
        logic [TIME_W-1:0]             apogee_ms;
        logic [2:0][ALT_W-1:0]         alt_hist;
        logic [4:0]                    alt_fill;
        logic [VEL_DEPTH-1:0][VEL_W-1:0] vel_ring;
        logic [3:0]                    vel_fill;
        logic signed [21:0]            vel_total;
        logic [3:0]                    slot;
    } flight_state_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic signed [ALT_W-1:0]     i_altitude_cm = '0;
    logic signed [VEL_W-1:0]     i_velocity_cms = '0;
    logic [ACC_W-1:0]            i_accel_magnitude_mms2 = '0;
    logic [TIME_W-1:0]           i_timestamp_ms = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic                        o_apogee_detected;
    logic                        o_apogee_now;
    logic signed [ALT_W-1:0]     o_apogee_altitude_cm;
    logic signed [ALT_W-1:0]     o_peak_altitude_cm;
    logic [CONF_W-1:0]           o_confidence_milli;
    logic [TIME_W-1:0]           o_apogee_time_ms;

    logic [MARGIN_W-1:0]  margin_cm = 17'd200;
    logic [CONFIRM_W-1:0] confirm_n = 5'd5;
    logic [ARMING_W-1:0]  arming_cm = 24'd5000;

    flight_state_t flight = '0;
    verdict_t      expected_verdicts[EXPECT_DEPTH];
    int            expect_wr = 0;
    int            expect_rd = 0;
    bit            hold_apogee = 1'b1;
    bit            failed = 1'b0;
    int            idle_pct = 0;
    int            stall_left = 0;
    int            quiet_cycles = 0;
    int            sent_count = 0;
    longint        clock_ms = 0;

    apogee_detector u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_altitude_cm          (i_altitude_cm),
        .i_velocity_cms         (i_velocity_cms),
        .i_accel_magnitude_mms2 (i_accel_magnitude_mms2),
        .i_timestamp_ms         (i_timestamp_ms),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_apogee_detected      (o_apogee_detected),
        .o_apogee_now           (o_apogee_now),
        .o_apogee_altitude_cm   (o_apogee_altitude_cm),
        .o_peak_altitude_cm     (o_peak_altitude_cm),
        .o_confidence_milli     (o_confidence_milli),
        .o_apogee_time_ms       (o_apogee_time_ms)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic flight_state_t next_flight_state(input flight_state_t s,
                                                        input sample_t x);
        longint alt, vel, acc, peak, total, bend;
        int need, weight;
        logic basic, advanced, vel_ok, curve_ok, fall_ok;
        alt = longint'($signed(x.alt));
        vel = longint'($signed(x.vel));
        acc = longint'(x.acc);
        need = (confirm_n == 0) ? 1 : int'(confirm_n);
        basic = 1'b0;
        advanced = 1'b0;
        s.fired = 1'b0;

        s.alt_hist[0] = s.alt_hist[1];
        s.alt_hist[1] = s.alt_hist[2];
        s.alt_hist[2] = x.alt;
        if (s.alt_fill < ALT_DEPTH) s.alt_fill = s.alt_fill + 5'd1;

        total = longint'($signed(s.vel_total));
        if (s.vel_fill >= VEL_DEPTH) total = total - $signed(s.vel_ring[s.slot]);
        s.vel_ring[s.slot] = x.vel;
        total = total + vel;
        s.vel_total = total[21:0];
        s.slot = (s.slot == VEL_DEPTH - 1) ? 4'd0 : s.slot + 4'd1;
        if (s.vel_fill < VEL_DEPTH) s.vel_fill = s.vel_fill + 4'd1;

        if (alt > $signed(s.peak)) s.peak = x.alt;
        peak = longint'($signed(s.peak));

        if (!s.detected && peak >= longint'(arming_cm)) begin
            if (int'(s.alt_fill) >= need) begin
                if (peak - alt > longint'(margin_cm)) begin
                    if (s.run != 5'd31) s.run = s.run + 5'd1;
                end else begin
                    s.run = '0;
                end
                basic = int'(s.run) >= need;
            end
            if (int'(s.vel_fill) >= need) begin
                vel_ok = (vel < -50) && (total < -20 * longint'(s.vel_fill));
                fall_ok = (acc < 10500) && (acc > 9000);
                curve_ok = 1'b0;
                if (s.alt_fill >= 3) begin
                    bend = longint'($signed(s.alt_hist[2])) - 2 * longint'($signed(s.alt_hist[1]))
                         + longint'($signed(s.alt_hist[0]));
                    curve_ok = bend < 0;
                end
                weight = (vel_ok ? 500 : 0) + (curve_ok ? 300 : 0) + (fall_ok ? 200 : 0);
                s.conf = CONF_W'((300 * weight + 700 * int'(s.conf)) / 1000);
                advanced = s.conf > 600;
            end
            if (advanced && (basic || s.conf > 800)) begin
                s.detected = 1'b1;
                s.fired = 1'b1;
                s.apogee_alt = s.peak;
                s.apogee_ms = x.ts;
            end
        end
        return s;
    endfunction

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            failed = 1'b1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        verdict_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expect_rd == expect_wr) begin
                failed = 1'b1;
                $display("%0t: result request with no sample pending", $time);
            end else begin
                want = expected_verdicts[expect_rd % EXPECT_DEPTH];
                expect_rd++;
                compare_field("apogee_detected", want.detected, o_apogee_detected);
                compare_field("apogee_now", want.fired, o_apogee_now);
                compare_field("apogee_altitude_cm", want.apogee_alt, o_apogee_altitude_cm);
                compare_field("peak_altitude_cm", want.peak, o_peak_altitude_cm);
                compare_field("confidence_milli", want.conf, o_confidence_milli);
                compare_field("apogee_time_ms", want.apogee_ms, o_apogee_time_ms);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input longint value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (index)
            CFG_DESCENT_MARGIN:  margin_cm = value[MARGIN_W-1:0];
            CFG_CONFIRM_SAMPLES: confirm_n = value[CONFIRM_W-1:0];
            CFG_ARMING_ALTITUDE: arming_cm = value[ARMING_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input longint margin, input longint confirm, input longint arming);
        write_register(CFG_DESCENT_MARGIN, margin);
        write_register(CFG_CONFIRM_SAMPLES, confirm);
        write_register(CFG_ARMING_ALTITUDE, arming);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expect_wr != expect_rd) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_sample(input longint alt, input longint vel, input longint acc,
                              input longint ts);
        sample_t x;
        flight_state_t trial;
        x.alt = ALT_W'(clip(alt, ALT_MIN, ALT_MAX));
        x.vel = VEL_W'(clip(vel, -VEL_LIM, VEL_LIM));
        x.acc = ACC_W'(clip(acc, 0, ACC_MAX));
        x.ts = ts[TIME_W-1:0];
        trial = next_flight_state(flight, x);
        // While detection is held off, a request that would declare apogee is
        // replaced by a level, climbing, non-free-fall sample that cannot.
        if (hold_apogee && trial.fired) begin
            x.alt = ALT_W'($signed(flight.peak) - longint'($urandom_range(0, margin_cm)));
            x.vel = VEL_W'($urandom_range(0, VEL_LIM));
            x.acc = ACC_W'($urandom_range(10500, ACC_MAX));
        end
        @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_altitude_cm <= x.alt;
        i_velocity_cms <= x.vel;
        i_accel_magnitude_mms2 <= x.acc;
        i_timestamp_ms <= x.ts;
        do @(posedge i_clk); while (!o_in_ready);
        flight = next_flight_state(flight, x);
        expected_verdicts[expect_wr % EXPECT_DEPTH] = verdict_t'{flight.detected, flight.fired,
                                                                 flight.apogee_alt, flight.peak,
                                                                 flight.conf, flight.apogee_ms};
        expect_wr++;
        sent_count++;
    endtask

    task automatic put_noise(input longint alt_hi);
        put_sample(longint'($urandom_range(0, 32'(alt_hi - ALT_MIN))) + ALT_MIN,
                   longint'($urandom_range(0, 2 * VEL_LIM)) - VEL_LIM,
                   $urandom_range(0, ACC_MAX), $urandom);
    endtask

    task automatic put_flight();
        longint alt, rate;
        int climb, fall;
        alt = $signed(flight.peak) - longint'($urandom_range(0, 5000));
        rate = 0;
        climb = $urandom_range(0, 8);
        fall = $urandom_range(2, 30);
        repeat (climb) begin
            alt = alt + $urandom_range(0, 3000);
            clock_ms = clock_ms + $urandom_range(1, 100);
            put_sample(alt, $urandom_range(1, VEL_LIM), $urandom_range(0, ACC_MAX), clock_ms);
        end
        repeat (fall) begin
            rate = rate + $urandom_range(0, 400);
            alt = alt - rate;
            clock_ms = clock_ms + $urandom_range(1, 100);
            put_sample(alt, -longint'($urandom_range(0, VEL_LIM)), $urandom_range(8500, 11000),
                       clock_ms);
        end
    endtask

    task automatic test_short_history();
        configure(0, 0, 0);
        put_sample(100, -100000, 10000, 0);
        put_sample(50, -60000, 9001, 1);
        put_sample(ALT_MIN, -1, 10499, 2);
    endtask

    task automatic test_before_arming();
        wait_idle();
        configure(200, 5, 5000);
        idle_pct = 20;
        put_sample(4999, 100000, 0, 'hFFFF_FFFF);
        put_sample(-1, -100000, ACC_MAX, 0);
        put_sample(0, 0, 9000, 3);
        put_sample(ALT_MIN, 51, 10500, 4);
        put_sample(4998, -51, 9001, 5);
        put_sample(4000, -50, 10499, 6);
        put_sample(-500000, 131071, 262143, 'h5555_5555);
        put_sample(1234, -131072, 1, 'hAAAA_AAAA);
        put_sample(2, 1, 131072, 7);
        put_sample(4999, -100000, 9800, 8);
    endtask

    task automatic test_confirm_beyond_history();
        wait_idle();
        configure(0, 20, 0);
        for (int k = 1; k <= 45; k++) begin
            clock_ms = clock_ms + 10;
            put_sample(4999 - 10 * k, -longint'($urandom_range(51, VEL_LIM)),
                       $urandom_range(9001, 10499), clock_ms);
        end
    endtask

    task automatic test_random_flights();
        longint peak;
        for (int phase = 0; phase < 7; phase++) begin
            wait_idle();
            peak = $signed(flight.peak);
            case (phase)
                0: begin configure(200, 5, 5000); idle_pct = 20; end
                1: begin configure(0, 1, 0); idle_pct = 0; end
                2: begin configure(100000, 10, $urandom_range(0, peak + 20000)); idle_pct = 40; end
                3: begin configure($urandom_range(0, 100000), 3, ALT_MAX); idle_pct = 25; end
                4: begin
                    configure($urandom_range(0, 2000), $urandom_range(0, 20),
                              $urandom_range(0, peak));
                    idle_pct = 15;
                end
                5: begin configure(50, 2, 0); idle_pct = 50; end
                default: begin
                    configure($urandom_range(0, 100000), $urandom_range(1, 20),
                              $urandom_range(0, peak + 5000));
                    idle_pct = 10;
                end
            endcase
            while (sent_count < 58 + 80 * (phase + 1)) begin
                if ($urandom_range(0, 9) < 3) begin
                    repeat ($urandom_range(1, 4)) put_noise($signed(flight.peak) + 5000);
                end else begin
                    put_flight();
                end
            end
        end
    endtask

    task automatic test_apogee_and_after();
        longint top;
        wait_idle();
        configure(200, 5, 0);
        idle_pct = 0;
        hold_apogee = 1'b0;
        top = $signed(flight.peak);
        for (int k = 1; k <= 5; k++) begin
            clock_ms = clock_ms + 20;
            put_sample(top + 2000 * k, 1000, 20000, clock_ms);
        end
        top = $signed(flight.peak);
        for (int k = 1; k <= 60 && !flight.detected; k++) begin
            clock_ms = clock_ms + 20;
            put_sample(top - 1000 * k - 50 * k * k, -3000, 9800, clock_ms);
        end
        put_sample(ALT_MAX, VEL_LIM, ACC_MAX, 'hFFFF_FFFF);
        put_sample(ALT_MIN, -VEL_LIM, 0, 0);
        repeat (40) put_noise(ALT_MAX);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_history();
        test_before_arming();
        test_confirm_beyond_history();
        test_random_flights();
        test_apogee_and_after();
        wait_idle();
        if (!failed && expect_wr == expect_rd) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/apgdet_pkg.sv
hw/rtl/apogee_detector.sv
sim/tb_top.sv
